@@ rtl/hoa_pkg.sv @@
// hoa_pkg: shared types and constants of the hierarchical object allocator
// no dependencies; imported by the interfaces, controller and datapath

package hoa_pkg;

    localparam int HANDLE_W = 13;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACHK,
        ST_SGO,
        ST_PRD,
        ST_PCALC,
        ST_PWR,
        ST_FDIV,
        ST_FRD,
        ST_FCHK,
        ST_FW1,
        ST_FW2,
        ST_EMIT
    } state_t;

    typedef enum logic [3:0] {
        CMD_IDLE,
        CMD_ACHK,
        CMD_SGO,
        CMD_PRD,
        CMD_PCALC,
        CMD_PWR,
        CMD_FDIV,
        CMD_FRD,
        CMD_FCHK,
        CMD_FW1,
        CMD_FW2,
        CMD_EMIT
    } cmd_t;

    typedef struct packed {
        logic in_valid;
        logic req_free;
        logic pool_empty;
        logic no_slot;
        logic steal_fail;
        logic no_free;
        logic bad_handle;
        logic idle_obj;
        logic emptied;
        logic pushed;
        logic emptied_q;
        logic out_free;
    } hoa_status_t;

endpackage

@@ rtl/hoa_req_if.sv @@
// hoa_req_if: request channel (allocate or free) with valid/ready handshake
// depends on hoa_pkg

interface hoa_req_if
    import hoa_pkg::*;
;
    logic                valid;
    logic                ready;
    logic                kind;
    logic [HANDLE_W-1:0] handle;

    modport source (output valid, output kind, output handle, input ready);
    modport sink (input valid, input kind, input handle, output ready);
endinterface

@@ rtl/hoa_rsp_if.sv @@
// hoa_rsp_if: result channel (handle and success flag) with valid/ready handshake
// depends on hoa_pkg

interface hoa_rsp_if
    import hoa_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [HANDLE_W-1:0] handle_res;
    logic                ok;

    modport source (output valid, output handle_res, output ok, input ready);
    modport sink (input valid, input handle_res, input ok, output ready);
endinterface

@@ rtl/hierarchical_object_allocator.sv @@
// channel  dir  handshake      payload
// req      in   valid/ready    kind (0 alloc, 1 free), handle[12:0]
// rsp      out  valid/ready    handle_res[12:0], ok
//
// one item at a time; allocate from a partly free block: check, read, calculate and
// write states, plus a slot step if a block comes from a slot; free: divide, read,
// check, link writes if the block moves lists, set by dependent read-modify-writes
// of the block record and link memories (one read port each, registered read)
// reset clears list heads, slot table and block record valid bits; no clearing pass
// a stalled result holds in the output register; the next item is taken once
// it is loaded there
// depends on hoa_pkg, hoa_req_if, hoa_rsp_if, hoa_ctrl, hoa_dp

module hierarchical_object_allocator
    import hoa_pkg::*;
#(
    parameter int SLOTS             = 4,
    parameter int BLOCKS_PER_SLOT   = 64,
    parameter int OBJECTS_PER_BLOCK = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    hoa_req_if.sink   req,
    hoa_rsp_if.source rsp
);

    cmd_t        cmd;
    hoa_status_t st;

    hoa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .cmd   (cmd)
    );

    hoa_dp #(
        .SLOTS             (SLOTS),
        .BLOCKS_PER_SLOT   (BLOCKS_PER_SLOT),
        .OBJECTS_PER_BLOCK (OBJECTS_PER_BLOCK)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cmd   (cmd),
        .st    (st)
    );

endmodule

@@ rtl/hoa_ram.sv @@
// hoa_ram: generic single write port, single read port ram with registered read
// no dependencies

module hoa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/hoa_ctrl.sv @@
// hoa_ctrl: sequencer of the allocator, one command per cycle to the datapath
// depends on hoa_pkg

module hoa_ctrl
    import hoa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  hoa_status_t st,
    output cmd_t        cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = CMD_IDLE;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd = CMD_IDLE;
                if (st.in_valid)
                begin
                    state_next = st.req_free ? ST_FDIV : ST_ACHK;
                end
            end
            ST_ACHK:
            begin
                cmd = CMD_ACHK;
                priority if (!st.pool_empty)
                begin
                    state_next = ST_PRD;
                end
                else if (st.no_slot)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_SGO;
                end
            end
            ST_SGO:
            begin
                cmd        = CMD_SGO;
                state_next = st.steal_fail ? ST_EMIT : ST_PRD;
            end
            ST_PRD:
            begin
                cmd        = CMD_PRD;
                state_next = ST_PCALC;
            end
            ST_PCALC:
            begin
                cmd        = CMD_PCALC;
                state_next = st.no_free ? ST_EMIT : ST_PWR;
            end
            ST_PWR:
            begin
                cmd        = CMD_PWR;
                state_next = ST_EMIT;
            end
            ST_FDIV:
            begin
                cmd        = CMD_FDIV;
                state_next = st.bad_handle ? ST_EMIT : ST_FRD;
            end
            ST_FRD:
            begin
                cmd        = CMD_FRD;
                state_next = ST_FCHK;
            end
            ST_FCHK:
            begin
                cmd = CMD_FCHK;
                priority if (st.idle_obj)
                begin
                    state_next = ST_EMIT;
                end
                else if (st.emptied || st.pushed)
                begin
                    state_next = ST_FW1;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_FW1:
            begin
                cmd        = CMD_FW1;
                state_next = st.emptied_q ? ST_FW2 : ST_EMIT;
            end
            ST_FW2:
            begin
                cmd        = CMD_FW2;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd = CMD_EMIT;
                if (st.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/hoa_dp.sv @@
// hoa_dp: allocator datapath: list heads, slot table, block and object memories
// depends on hoa_pkg, hoa_ram, hoa_req_if, hoa_rsp_if

module hoa_dp
    import hoa_pkg::*;
#(
    parameter int SLOTS             = 4,
    parameter int BLOCKS_PER_SLOT   = 64,
    parameter int OBJECTS_PER_BLOCK = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    hoa_req_if.sink     req,
    hoa_rsp_if.source   rsp,
    input  cmd_t        cmd,
    output hoa_status_t st
);

    localparam int NBLK = SLOTS * BLOCKS_PER_SLOT;
    localparam int NOBJ = NBLK * OBJECTS_PER_BLOCK;
    localparam int BW   = $clog2(NBLK);
    localparam int BLW  = $clog2(NBLK + 1);
    localparam int OW   = $clog2(OBJECTS_PER_BLOCK);
    localparam int OCW  = $clog2(OBJECTS_PER_BLOCK + 1);
    localparam int SW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SLW  = $clog2(SLOTS + 1);
    localparam int SCW  = $clog2(BLOCKS_PER_SLOT + 1);
    localparam int AW   = $clog2(NOBJ);
    localparam int IW   = 3 * OCW;
    // reciprocals for handle -> block and block -> slot
    localparam int KB   = HANDLE_W + OW + 1;
    localparam int KS   = HANDLE_W + $clog2(BLOCKS_PER_SLOT) + 1;
    localparam logic [KB-1:0] RBV = KB'(((64'd1 << KB) + OBJECTS_PER_BLOCK - 1)
                                        / OBJECTS_PER_BLOCK);
    localparam logic [KS-1:0] RSV = KS'(((64'd1 << KS) + BLOCKS_PER_SLOT - 1)
                                        / BLOCKS_PER_SLOT);
    localparam logic [HANDLE_W:0] HLIM = (NOBJ > (1 << HANDLE_W)) ?
        (HANDLE_W+1)'(1 << HANDLE_W) : (HANDLE_W+1)'(NOBJ);

    localparam logic [BLW-1:0] BNULL = BLW'(NBLK);
    localparam logic [OCW-1:0] ONULL = OCW'(OBJECTS_PER_BLOCK);
    localparam logic [SLW-1:0] SNULL = SLW'(SLOTS);
    localparam logic [SCW-1:0] BFULL = SCW'(BLOCKS_PER_SLOT);

    // list heads and slot table
    logic [BLW-1:0] pool_head_reg, pool_head_next;
    logic [SLW-1:0] gh_reg, gh_next;
    logic [BLW-1:0] sbh_reg [SLOTS];
    logic [BLW-1:0] sbh_next [SLOTS];
    logic [SCW-1:0] sused_reg [SLOTS];
    logic [SCW-1:0] sused_next [SLOTS];
    logic [SCW-1:0] sfm_reg [SLOTS];
    logic [SCW-1:0] sfm_next [SLOTS];
    logic [SLW-1:0] sprev_reg [SLOTS];
    logic [SLW-1:0] sprev_next [SLOTS];
    logic [SLW-1:0] snext_reg [SLOTS];
    logic [SLW-1:0] snext_next [SLOTS];
    logic [SLOTS-1:0] suse_reg, suse_next;
    logic [NBLK-1:0]  blk_vld_reg;
    logic             vld_q_reg;

    // working registers of one item
    logic [HANDLE_W-1:0] h_reg, h_next;
    logic [HANDLE_W-1:0] bq_reg, bq_next;
    logic [BW-1:0]       b_reg, b_next;
    logic [OW-1:0]       o_reg, o_next;
    logic [SW-1:0]       s_reg, s_next;
    logic [OCW-1:0]      fh_reg, fh_next, uc_reg, uc_next, fm_reg, fm_next;
    logic [BLW-1:0]      p_reg, p_next, n_reg, n_next, sh_reg, sh_next;
    logic                use_link_reg, use_link_next;
    logic                emptied_reg, emptied_next;
    logic [HANDLE_W-1:0] res_h_reg, res_h_next;
    logic                res_ok_reg, res_ok_next;
    logic [HANDLE_W-1:0] out_h_reg;
    logic                out_ok_reg;
    logic                out_valid_reg;

    // memory ports
    logic           info_we;
    logic [BW-1:0]  info_waddr, info_raddr;
    logic [IW-1:0]  info_wdata, info_q;
    logic           prev_we, next_we;
    logic [BW-1:0]  prev_waddr, prev_raddr, next_waddr, next_raddr;
    logic [BLW-1:0] prev_wdata, prev_q, next_wdata, next_q;
    logic           obj_we;
    logic [AW-1:0]  obj_waddr, obj_raddr;
    logic [OCW-1:0] obj_wdata, obj_q;

    logic [OCW-1:0] fh_c, uc_c, fm_c;
    logic [HANDLE_W+KB-1:0] prodb;
    logic [HANDLE_W+KS-1:0] prods;
    logic [SW-1:0]  sel;
    logic           found;
    logic           out_free;

    hoa_ram #(.WIDTH(IW), .DEPTH(NBLK)) u_info_ram (
        .clk(clk), .we(info_we), .waddr(info_waddr), .wdata(info_wdata),
        .raddr(info_raddr), .rdata(info_q)
    );

    hoa_ram #(.WIDTH(BLW), .DEPTH(NBLK)) u_prev_ram (
        .clk(clk), .we(prev_we), .waddr(prev_waddr), .wdata(prev_wdata),
        .raddr(prev_raddr), .rdata(prev_q)
    );

    hoa_ram #(.WIDTH(BLW), .DEPTH(NBLK)) u_next_ram (
        .clk(clk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
        .raddr(next_raddr), .rdata(next_q)
    );

    hoa_ram #(.WIDTH(OCW), .DEPTH(NOBJ)) u_obj_ram (
        .clk(clk), .we(obj_we), .waddr(obj_waddr), .wdata(obj_wdata),
        .raddr(obj_raddr), .rdata(obj_q)
    );

    // block record that was never written reads as empty and untouched
    assign {fh_c, uc_c, fm_c} = vld_q_reg ? info_q : {ONULL, {OCW{1'b0}}, {OCW{1'b0}}};

    assign prodb    = (HANDLE_W+KB)'(h_reg) * (HANDLE_W+KB)'(RBV);
    assign prods    = (HANDLE_W+KS)'(bq_reg) * (HANDLE_W+KS)'(RSV);
    assign out_free = !out_valid_reg || rsp.ready;

    assign req.ready      = (cmd == CMD_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.handle_res = out_h_reg;
    assign rsp.ok         = out_ok_reg;

    always_comb
    begin
        found = 1'b0;
        sel   = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (!found && !suse_reg[i])
            begin
                found = 1'b1;
                sel   = SW'(i);
            end
        end
    end

    always_comb
    begin
        logic [SW-1:0]  s;
        logic [BW-1:0]  bn;
        logic [BLW-1:0] ph, pp, nn;
        logic [SLW-1:0] gp, gn;
        logic [OCW-1:0] fhn, fmn, ucn;
        logic [SCW-1:0] cnt;
        logic [HANDLE_W-1:0] rem;
        logic           unlink_pool, unlink_glob, push_glob, swe;

        s           = s_reg;
        bn          = b_reg;
        ph          = pool_head_reg;
        pp          = p_reg;
        nn          = n_reg;
        gp          = '0;
        gn          = '0;
        fhn         = fh_reg;
        fmn         = fm_reg;
        ucn         = uc_reg;
        cnt         = '0;
        rem         = '0;
        unlink_pool = 1'b0;
        unlink_glob = 1'b0;
        push_glob   = 1'b0;
        swe         = 1'b0;

        pool_head_next = pool_head_reg;
        gh_next        = gh_reg;
        sbh_next       = sbh_reg;
        sused_next     = sused_reg;
        sfm_next       = sfm_reg;
        sprev_next     = sprev_reg;
        snext_next     = snext_reg;
        suse_next      = suse_reg;
        h_next         = h_reg;
        bq_next        = bq_reg;
        b_next         = b_reg;
        o_next         = o_reg;
        s_next         = s_reg;
        fh_next        = fh_reg;
        uc_next        = uc_reg;
        fm_next        = fm_reg;
        p_next         = p_reg;
        n_next         = n_reg;
        sh_next        = sh_reg;
        use_link_next  = use_link_reg;
        emptied_next   = emptied_reg;
        res_h_next     = res_h_reg;
        res_ok_next    = res_ok_reg;

        info_we    = 1'b0;
        info_waddr = b_reg;
        info_wdata = '0;
        info_raddr = b_reg;
        prev_we    = 1'b0;
        prev_waddr = b_reg;
        prev_wdata = BNULL;
        prev_raddr = b_reg;
        next_we    = 1'b0;
        next_waddr = b_reg;
        next_wdata = BNULL;
        next_raddr = b_reg;
        obj_we     = 1'b0;
        obj_waddr  = AW'(h_reg);
        obj_wdata  = '0;
        obj_raddr  = '0;

        st            = '0;
        st.in_valid   = req.valid;
        st.req_free   = req.kind;
        st.pool_empty = (pool_head_reg >= BNULL);
        st.no_slot    = (gh_reg >= SNULL) && !found;
        st.emptied_q  = emptied_reg;
        st.out_free   = out_free;

        unique case (cmd)
            CMD_IDLE:
            begin
                if (req.valid)
                begin
                    h_next = req.handle;
                end
            end
            CMD_ACHK:
            begin
                priority if (pool_head_reg < BNULL)
                begin
                    b_next = pool_head_reg[BW-1:0];
                end
                else if (gh_reg < SNULL)
                begin
                    s_next     = gh_reg[SW-1:0];
                    next_raddr = sbh_reg[gh_reg[SW-1:0]][BW-1:0];
                end
                else if (found)
                begin
                    // open the lowest idle slot
                    s_next          = sel;
                    suse_next[sel]  = 1'b1;
                    sbh_next[sel]   = BNULL;
                    sfm_next[sel]   = '0;
                    sused_next[sel] = '0;
                    snext_next[sel] = SNULL;
                    sprev_next[sel] = SNULL;
                    gh_next         = SLW'(sel);
                end
                else
                begin
                    res_h_next  = '0;
                    res_ok_next = 1'b0;
                end
            end
            CMD_SGO:
            begin
                st.steal_fail = (sbh_reg[s] >= BNULL) && (sfm_reg[s] >= BFULL);
                if (sbh_reg[s] < BNULL)
                begin
                    bn          = sbh_reg[s][BW-1:0];
                    sbh_next[s] = (next_q < BNULL) ? next_q : BNULL;
                end
                else if (sfm_reg[s] < BFULL)
                begin
                    bn          = BW'(s * BLOCKS_PER_SLOT + int'(sfm_reg[s]));
                    sfm_next[s] = sfm_reg[s] + 1'b1;
                    info_we     = 1'b1;
                    info_waddr  = bn;
                    info_wdata  = {ONULL, {OCW{1'b0}}, {OCW{1'b0}}};
                end
                if (st.steal_fail)
                begin
                    res_h_next  = '0;
                    res_ok_next = 1'b0;
                end
                else
                begin
                    sused_next[s]  = sused_reg[s] + 1'b1;
                    unlink_glob    = !((sbh_next[s] < BNULL) || (sfm_next[s] < BFULL));
                    pool_head_next = BLW'(bn);
                    b_next         = bn;
                    prev_we        = 1'b1;
                    prev_waddr     = bn;
                    prev_wdata     = BNULL;
                    next_we        = 1'b1;
                    next_waddr     = bn;
                    next_wdata     = BNULL;
                end
            end
            CMD_PRD:
            begin
                info_raddr = b_reg;
                prev_raddr = b_reg;
                next_raddr = b_reg;
            end
            CMD_PCALC:
            begin
                st.no_free    = (fh_c >= ONULL) && (fm_c >= ONULL);
                fh_next       = fh_c;
                uc_next       = uc_c;
                fm_next       = fm_c;
                p_next        = prev_q;
                n_next        = next_q;
                use_link_next = (fh_c < ONULL);
                o_next        = (fh_c < ONULL) ? fh_c[OW-1:0] : fm_c[OW-1:0];
                obj_raddr     = AW'(int'(b_reg) * OBJECTS_PER_BLOCK + int'(fh_c[OW-1:0]));
                if (st.no_free)
                begin
                    res_h_next  = '0;
                    res_ok_next = 1'b0;
                end
            end
            CMD_PWR:
            begin
                if (use_link_reg)
                begin
                    fhn = (obj_q > ONULL) ? ONULL : obj_q;
                    fmn = fm_reg;
                end
                else
                begin
                    fhn = fh_reg;
                    fmn = fm_reg + 1'b1;
                end
                ucn         = uc_reg + 1'b1;
                info_we     = 1'b1;
                info_waddr  = b_reg;
                info_wdata  = {fhn, ucn, fmn};
                unlink_pool = !((fhn < ONULL) || (fmn < ONULL));
                pp          = p_reg;
                nn          = n_reg;
                res_h_next  = HANDLE_W'(int'(b_reg) * OBJECTS_PER_BLOCK + int'(o_reg));
                res_ok_next = 1'b1;
            end
            CMD_FDIV:
            begin
                res_h_next    = h_reg;
                res_ok_next   = 1'b1;
                st.bad_handle = ({1'b0, h_reg} >= HLIM);
                bq_next       = prodb[HANDLE_W+KB-1:KB];
            end
            CMD_FRD:
            begin
                rem        = h_reg - HANDLE_W'(int'(bq_reg) * OBJECTS_PER_BLOCK);
                b_next     = bq_reg[BW-1:0];
                o_next     = rem[OW-1:0];
                s_next     = SW'(prods[HANDLE_W+KS-1:KS]);
                info_raddr = bq_reg[BW-1:0];
                prev_raddr = bq_reg[BW-1:0];
                next_raddr = bq_reg[BW-1:0];
            end
            CMD_FCHK:
            begin
                st.idle_obj  = !suse_reg[s] || (uc_c == '0);
                emptied_next = 1'b0;
                if (!st.idle_obj)
                begin
                    obj_we     = 1'b1;
                    obj_waddr  = AW'(h_reg);
                    obj_wdata  = fh_c;
                    ucn        = uc_c - 1'b1;
                    info_we    = 1'b1;
                    info_waddr = b_reg;
                    info_wdata = {OCW'(o_reg), ucn, fm_c};
                    if (ucn == '0)
                    begin
                        // block drained: back to its slot
                        st.emptied    = 1'b1;
                        emptied_next  = 1'b1;
                        swe           = !((sbh_reg[s] < BNULL) || (sfm_reg[s] < BFULL));
                        unlink_pool   = 1'b1;
                        pp            = prev_q;
                        nn            = next_q;
                        sh_next       = sbh_reg[s];
                        sbh_next[s]   = BLW'(b_reg);
                        cnt           = (sused_reg[s] != '0) ? sused_reg[s] - 1'b1 : '0;
                        sused_next[s] = cnt;
                        if (cnt == '0)
                        begin
                            unlink_glob  = 1'b1;
                            suse_next[s] = 1'b0;
                        end
                        else if (swe)
                        begin
                            push_glob = 1'b1;
                        end
                    end
                    else if (!((fh_c < ONULL) || (fm_c < ONULL)))
                    begin
                        // block was full: push it on the pool list
                        st.pushed      = 1'b1;
                        next_we        = 1'b1;
                        next_waddr     = b_reg;
                        next_wdata     = (pool_head_reg < BNULL) ? pool_head_reg : BNULL;
                        if (pool_head_reg < BNULL)
                        begin
                            prev_we    = 1'b1;
                            prev_waddr = pool_head_reg[BW-1:0];
                            prev_wdata = BLW'(b_reg);
                        end
                        pool_head_next = BLW'(b_reg);
                    end
                end
            end
            CMD_FW1:
            begin
                if (emptied_reg)
                begin
                    next_we    = 1'b1;
                    next_waddr = b_reg;
                    next_wdata = (sh_reg < BNULL) ? sh_reg : BNULL;
                    if (sh_reg < BNULL)
                    begin
                        prev_we    = 1'b1;
                        prev_waddr = sh_reg[BW-1:0];
                        prev_wdata = BLW'(b_reg);
                    end
                end
                else
                begin
                    prev_we    = 1'b1;
                    prev_waddr = b_reg;
                    prev_wdata = BNULL;
                end
            end
            CMD_FW2:
            begin
                prev_we    = 1'b1;
                prev_waddr = b_reg;
                prev_wdata = BNULL;
            end
            CMD_EMIT:
            begin
            end
            default:
            begin
            end
        endcase

        // pool list removal of b_reg
        if (unlink_pool)
        begin
            if (ph == BLW'(b_reg))
            begin
                ph = (nn < BNULL) ? nn : BNULL;
            end
            else if (pp < BNULL)
            begin
                next_we    = 1'b1;
                next_waddr = pp[BW-1:0];
                next_wdata = (nn < BNULL) ? nn : BNULL;
            end
            if (nn < BNULL)
            begin
                prev_we    = 1'b1;
                prev_waddr = nn[BW-1:0];
                prev_wdata = ((pp < BNULL) && (ph != nn)) ? pp : BNULL;
            end
            pool_head_next = ph;
        end

        // global list removal of slot s
        if (unlink_glob)
        begin
            gp = sprev_next[s];
            gn = snext_next[s];
            if (gh_next == SLW'(s))
            begin
                gh_next = (gn < SNULL) ? gn : SNULL;
            end
            else if (gp < SNULL)
            begin
                snext_next[gp[SW-1:0]] = (gn < SNULL) ? gn : SNULL;
            end
            if (gn < SNULL)
            begin
                sprev_next[gn[SW-1:0]] = ((gp < SNULL) && (gh_next != gn)) ? gp : SNULL;
            end
        end

        if (push_glob)
        begin
            snext_next[s] = (gh_next < SNULL) ? gh_next : SNULL;
            if (gh_next < SNULL)
            begin
                sprev_next[gh_next[SW-1:0]] = SLW'(s);
            end
            sprev_next[s] = SNULL;
            gh_next       = SLW'(s);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_head_reg <= BNULL;
            gh_reg        <= SNULL;
            suse_reg      <= '0;
            blk_vld_reg   <= '0;
            emptied_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < SLOTS; i++)
            begin
                sbh_reg[i]   <= BNULL;
                sused_reg[i] <= '0;
                sfm_reg[i]   <= '0;
                sprev_reg[i] <= SNULL;
                snext_reg[i] <= SNULL;
            end
        end
        else
        begin
            pool_head_reg <= pool_head_next;
            gh_reg        <= gh_next;
            suse_reg      <= suse_next;
            sbh_reg       <= sbh_next;
            sused_reg     <= sused_next;
            sfm_reg       <= sfm_next;
            sprev_reg     <= sprev_next;
            snext_reg     <= snext_next;
            emptied_reg   <= emptied_next;
            if (info_we)
            begin
                blk_vld_reg[info_waddr] <= 1'b1;
            end
            if (cmd == CMD_EMIT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        vld_q_reg    <= blk_vld_reg[info_raddr];
        h_reg        <= h_next;
        bq_reg       <= bq_next;
        b_reg        <= b_next;
        o_reg        <= o_next;
        s_reg        <= s_next;
        fh_reg       <= fh_next;
        uc_reg       <= uc_next;
        fm_reg       <= fm_next;
        p_reg        <= p_next;
        n_reg        <= n_next;
        sh_reg       <= sh_next;
        use_link_reg <= use_link_next;
        res_h_reg    <= res_h_next;
        res_ok_reg   <= res_ok_next;
        if (cmd == CMD_EMIT && out_free)
        begin
            out_h_reg  <= res_h_reg;
            out_ok_reg <= res_ok_reg;
        end
    end

endmodule
